// ===== design/dtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_pkg: shared types and constants of the decimal text to double unit
// Character codes, power classes, the job record between the front and the
// back, and the elaboration-time builder of the power-of-ten table.
// ----------------------------------------------------------------------------
package dtd_pkg;

  localparam int CharW    = 8;
  localparam int MantW    = 63;
  localparam int DblW     = 64;
  localparam int PowIdxW  = 10;
  localparam int PowCount = 632;
  localparam int POW_MIN  = -323;
  localparam int POW_MAX  = 308;

  // Mantissa limit up to which another digit is still taken without overflow
  localparam logic [MantW-1:0] ACCEPT_LIMIT = 63'd922337203685477578;

  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_E_UP  = 8'h45;
  localparam logic [CharW-1:0] CH_E_LO  = 8'h65;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;

  // Range class of the total power of ten
  typedef enum logic [1:0] {
    PCLS_FINITE = 2'd0,
    PCLS_HUGE   = 2'd1,
    PCLS_TINY   = 2'd2
  } pcls_e;

  // One finished number, handed from the front to the back
  typedef struct packed {
    logic               neg;
    logic [MantW-1:0]   mant;
    pcls_e              pcls;
    logic [PowIdxW-1:0] pidx;
    logic [CharW-1:0]   endc;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Correctly rounded double of 10^k, returned as a normalized form:
  // bits [63:52] signed unbiased exponent, bits [51:0] fraction below the
  // implicit one. Subnormal powers are rounded at subnormal precision.
  function automatic logic [63:0] pow10_entry(input int k);
    logic [1199:0] big;
    logic [1199:0] kept;
    logic [1199:0] low_mask;
    logic [63:0]   r;
    logic [63:0]   rn;
    logic          g;
    logic          rest;
    logic          sticky;
    int            base;
    int            msb;
    int            rmsb;
    int            sh;
    int            ex;
    big    = 1200'd1;
    base   = 0;
    sticky = 1'b0;
    kept   = '0;
    g      = 1'b0;
    if (k >= 0) begin
      for (int i = 0; i < k; i++) big = big * 1200'd10;
    end else begin
      // Scaled reciprocal; 2^n is never a multiple of 5, so it is inexact
      big    = 1200'd1 << 1130;
      base   = -1130;
      sticky = 1'b1;
      for (int i = 0; i < -k; i++) big = big / 1200'd10;
    end
    msb = 0;
    for (int i = 0; i < 1200; i++) if (big[i]) msb = i;
    if (msb + base >= -1022) sh = msb - 52;
    else sh = -1074 - base;
    if (sh <= 0) begin
      r = 64'(big << (-sh));
    end else begin
      kept     = big >> sh;
      g        = big[sh-1];
      low_mask = (1200'd1 << (sh - 1)) - 1200'd1;
      rest     = sticky | ((big & low_mask) != '0);
      r        = kept[63:0] + 64'(g & (rest | kept[0]));
    end
    rmsb = 0;
    for (int i = 0; i < 64; i++) if (r[i]) rmsb = i;
    ex = rmsb + sh + base;
    rn = r << (52 - rmsb);
    return {12'(ex), rn[51:0]};
  endfunction

endpackage

// ===== design/dtd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_if: stream channels of the decimal text to double unit
// Character input channel and value output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source(output valid, output char_code, input ready);
  modport sink(input valid, input char_code, output ready);
endinterface

interface dtd_value_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic [7:0]  end_char;
  modport source(output valid, output value_bits, output end_char, input ready);
  modport sink(input valid, input value_bits, input end_char, output ready);
endinterface

// ===== design/decimal_text_to_double_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_double_unit: streaming decimal text to IEEE 754 double
// Parses '-'? digits ('.' digits)? ([eE] '-'? digits)? one character a
// cycle while ready and emits the double and the terminating character.
// ----------------------------------------------------------------------------
// While its results are taken, the unit takes one character per clock, with
// no gaps between numbers. Characters that continue a number produce
// nothing; the first character outside the grammar ends the number, and its
// double value comes out together with that character. The parser forms the
// job in the accepting cycle and writes it into the two-entry job queue at
// that edge, the queue hands it to the converter when the converter
// advances, and it then passes through the nine-stage converter pipeline.
// The pipeline length is set by the 632-entry power-of-ten table with a
// registered read and the 53x53-bit multiply done as four 32-bit partial
// products followed by two addition stages and the rounding stages. While
// the result is not taken the converter holds, the queue fills, and once
// two numbers wait in the queue the character input drops ready.
// ----------------------------------------------------------------------------
module decimal_text_to_double_unit import dtd_pkg::*; #(
  parameter int EXPONENT_BITS = 20
) (
  input logic         clk_i,
  input logic         rst_ni,
  dtd_char_if.sink    char_i,
  dtd_value_if.source value_o
);

  logic   push;
  logic   pop;
  job_t   job_in;
  job_t   job_out;
  qstat_t qstat;

  // Parser
  dtd_front #(
    .ExpBits(EXPONENT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (char_i.valid),
    .char_code_i(char_i.char_code),
    .ready_o    (char_i.ready),
    .qstat_i    (qstat),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Decoupling queue
  dtd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .qstat_o(qstat)
  );

  // Converter
  dtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (value_o.valid),
    .out_ready_i (value_o.ready),
    .value_bits_o(value_o.value_bits),
    .end_char_o  (value_o.end_char)
  );

endmodule

// ===== design/dtd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_front: character parser
// Classifies each character against the number grammar, builds mantissa and
// exponents, and on the terminating character emits one job.
// ----------------------------------------------------------------------------
module dtd_front import dtd_pkg::*; #(
  parameter int ExpBits = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [CharW-1:0] char_code_i,
  output logic             ready_o,
  input  qstat_t           qstat_i,
  output logic             push_o,
  output job_t             job_o
);

  localparam int PowW  = ExpBits + 1;
  localparam int EexpW = ExpBits - 1;
  localparam int EmacW = EexpW + 4;
  localparam logic signed [ExpBits-1:0] DEXP_MAX = {1'b0, {(ExpBits-1){1'b1}}};
  localparam logic signed [ExpBits-1:0] DEXP_MIN = {1'b1, {(ExpBits-1){1'b0}}};
  localparam logic signed [ExpBits-1:0] DEXP_ONE = ExpBits'(1);
  localparam logic [EexpW-1:0]          EEXP_MAX = '1;
  localparam logic signed [PowW-1:0]    POW_HI   = PowW'(POW_MAX);
  localparam logic signed [PowW-1:0]    POW_LO   = PowW'(POW_MIN);

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_INT   = 5'b00010,
    PH_FRAC  = 5'b00100,
    PH_ESIGN = 5'b01000,
    PH_EDIG  = 5'b10000
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic                       neg_q, neg_d;
  logic [MantW-1:0]           mant_q, mant_d;
  logic signed [ExpBits-1:0]  dexp_q, dexp_d;
  logic [EexpW-1:0]           eexp_q, eexp_d;
  logic                       eneg_q, eneg_d;

  logic                       fire;
  logic                       term;
  logic                       is_digit;
  logic                       is_emark;
  logic [CharW-1:0]           diff;
  logic [3:0]                 digit;
  logic                       mant_fits;
  logic [MantW-1:0]           mant_mac;
  logic signed [ExpBits-1:0]  dexp_inc;
  logic signed [ExpBits-1:0]  dexp_dec;
  logic [EmacW-1:0]           eexp_wide;
  logic [EexpW-1:0]           eexp_mac;
  logic signed [PowW-1:0]     pw_dexp;
  logic signed [PowW-1:0]     pw_eexp;
  logic signed [PowW-1:0]     pow_total;

  assign ready_o = !qstat_i.full;
  assign fire    = valid_i & ready_o;

  // Classify the character
  assign is_digit = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign is_emark = (char_code_i == CH_E_LO) || (char_code_i == CH_E_UP);
  assign diff     = char_code_i - CH_ZERO;
  assign digit    = diff[3:0];

  // Digit arithmetic: times ten plus digit, saturating exponent steps
  assign mant_fits = mant_q <= ACCEPT_LIMIT;
  assign mant_mac  = (mant_q << 3) + (mant_q << 1) + MantW'(digit);
  assign dexp_inc  = (dexp_q == DEXP_MAX) ? dexp_q : dexp_q + DEXP_ONE;
  assign dexp_dec  = (dexp_q == DEXP_MIN) ? dexp_q : dexp_q - DEXP_ONE;
  assign eexp_wide = (EmacW'(eexp_q) << 3) + (EmacW'(eexp_q) << 1) + EmacW'(digit);
  assign eexp_mac  = (eexp_wide > EmacW'(EEXP_MAX)) ? EEXP_MAX : EexpW'(eexp_wide);

  // Grammar step
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mant_d  = mant_q;
    dexp_d  = dexp_q;
    eexp_d  = eexp_q;
    eneg_d  = eneg_q;
    term    = 1'b0;
    case (phase_q)
      PH_FRAC: begin
        if (is_digit) begin
          if (mant_fits) begin
            mant_d = mant_mac;
            dexp_d = dexp_dec;
          end
        end else if (is_emark) begin
          phase_d = PH_ESIGN;
        end else begin
          term = 1'b1;
        end
      end
      PH_ESIGN, PH_EDIG: begin
        if (is_digit) begin
          eexp_d  = eexp_mac;
          phase_d = PH_EDIG;
        end else if ((phase_q == PH_ESIGN) && (char_code_i == CH_MINUS)) begin
          eneg_d  = 1'b1;
          phase_d = PH_EDIG;
        end else begin
          term = 1'b1;
        end
      end
      default: begin
        if (is_digit) begin
          if (mant_fits) mant_d = mant_mac;
          else dexp_d = dexp_inc;
          phase_d = PH_INT;
        end else if ((phase_q != PH_INT) && (char_code_i == CH_MINUS)) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end else if (char_code_i == CH_DOT) begin
          phase_d = PH_FRAC;
        end else if (is_emark) begin
          phase_d = PH_ESIGN;
        end else begin
          term = 1'b1;
        end
      end
    endcase
  end

  // Total power of ten and its range class
  assign pw_dexp   = PowW'(dexp_q);
  assign pw_eexp   = signed'(PowW'({1'b0, eexp_q}));
  assign pow_total = pw_dexp + (eneg_q ? -pw_eexp : pw_eexp);

  always_comb begin
    job_o.neg  = neg_q;
    job_o.mant = mant_q;
    job_o.endc = char_code_i;
    job_o.pidx = '0;
    if (pow_total > POW_HI) begin
      job_o.pcls = PCLS_HUGE;
    end else if (pow_total < POW_LO) begin
      job_o.pcls = PCLS_TINY;
    end else begin
      job_o.pcls = PCLS_FINITE;
      job_o.pidx = PowIdxW'(pow_total - POW_LO);
    end
  end

  assign push_o = fire & term;

  // Advance the parse state; clear it once a number is handed off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      mant_q  <= '0;
      dexp_q  <= '0;
      eexp_q  <= '0;
      eneg_q  <= 1'b0;
    end else if (fire) begin
      if (term) begin
        phase_q <= PH_START;
        neg_q   <= 1'b0;
        mant_q  <= '0;
        dexp_q  <= '0;
        eexp_q  <= '0;
        eneg_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mant_q  <= mant_d;
        dexp_q  <= dexp_d;
        eexp_q  <= eexp_d;
        eneg_q  <= eneg_d;
      end
    end
  end

endmodule

// ===== design/dtd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_queue: job queue between parser and converter
// Two-entry FIFO that lets the parser and the converter stall independently.
// ----------------------------------------------------------------------------
module dtd_queue import dtd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  job_t   job_i,
  input  logic   pop_i,
  output job_t   job_o,
  output qstat_t qstat_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [PtrW:0]   cnt_q;

  assign job_o         = mem_q[rd_q];
  assign qstat_o.full  = cnt_q == (PtrW + 1)'(Depth);
  assign qstat_o.empty = cnt_q == '0;

  // Store the incoming job
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  // Move pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== design/dtd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_back: mantissa times power-of-ten converter
// Nine-stage pipeline: normalize and round the integer to double, look up
// the power of ten, multiply in 32-bit partial products, round the product
// with subnormal and overflow handling. The last stage is the output
// register; the whole pipe stalls while that register is held.
// ----------------------------------------------------------------------------
module dtd_back import dtd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  job_t             job_i,
  input  qstat_t           qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DblW-1:0]  value_bits_o,
  output logic [CharW-1:0] end_char_o
);

  localparam int NumStg = 9;

  typedef struct packed {
    logic             neg;
    logic             zero;
    pcls_e            pcls;
    logic [CharW-1:0] endc;
  } meta_t;

  logic [NumStg-1:0]   vld_q;
  meta_t               meta_q [NumStg];
  logic                adv;

  logic [DblW-1:0]     pow_rom [PowCount];
  logic [DblW-1:0]     rom_q;

  // stage 1
  logic [DblW-1:0]     m0;
  logic [2:0]          lzb;
  logic [DblW-1:0]     m1_q;
  logic [2:0]          lzb_q;
  logic [PowIdxW-1:0]  pidx_q;
  // stage 2
  logic [2:0]          lzf;
  logic [5:0]          lzt;
  logic [DblW-1:0]     m2_q;
  logic [5:0]          ea2_q;
  // stage 3
  logic [52:0]         sig_a;
  logic                ga;
  logic                sta;
  logic [53:0]         sa;
  logic [52:0]         siga_q;
  logic [6:0]          ea3_q;
  logic [52:0]         sigb_q;
  logic [11:0]         eb_q;
  // stage 4
  logic [63:0]         pp_ll_q;
  logic [52:0]         pp_lh_q;
  logic [52:0]         pp_hl_q;
  logic [41:0]         pp_hh_q;
  logic signed [12:0]  esum4_q;
  // stage 5
  logic [63:0]         pp_ll5_q;
  logic [53:0]         mid_q;
  logic [41:0]         pp_hh5_q;
  logic signed [12:0]  esum5_q;
  // stage 6
  logic [105:0]        prod_q;
  logic signed [12:0]  biased_q;
  // stage 7
  logic                top;
  logic [105:0]        norm;
  logic signed [12:0]  bexp;
  logic signed [12:0]  amt;
  logic [54:0]         x_q;
  logic [5:0]          sh_q;
  logic [10:0]         field7_q;
  logic                ovf7_q;
  // stage 8
  logic [54:0]         ysh;
  logic                lost;
  logic [52:0]         sig8_q;
  logic                g8_q;
  logic                st8_q;
  logic [10:0]         field8_q;
  logic                ovf8_q;
  // stage 9
  logic [62:0]         body;
  logic [DblW-1:0]     value;
  logic [DblW-1:0]     out_q;
  meta_t               m8;

  assign adv          = !vld_q[NumStg-1] | out_ready_i;
  assign pop_o        = adv & !qstat_i.empty;
  assign out_valid_o  = vld_q[NumStg-1];
  assign value_bits_o = out_q;
  assign end_char_o   = meta_q[NumStg-1].endc;

  // Power-of-ten table, built at elaboration
  for (genvar g = 0; g < PowCount; g++) begin : g_rom
    assign pow_rom[g] = pow10_entry(g + POW_MIN);
  end

  // Advance stage valids and per-item metadata
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= '{neg: job_i.neg, zero: (job_i.mant == '0), pcls: job_i.pcls,
                     endc: job_i.endc};
      for (int i = 1; i < NumStg; i++) meta_q[i] <= meta_q[i-1];
    end
  end

  // Stage 1: coarse normalize by whole bytes
  assign m0 = {1'b0, job_i.mant};
  always_comb begin
    lzb = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (m0[8*i +: 8] != 8'd0) lzb = 3'(7 - i);
    end
  end

  // Stage 2: fine normalize within the top byte
  always_comb begin
    lzf = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (m1_q[56 + i]) lzf = 3'(7 - i);
    end
  end
  assign lzt = {lzb_q, lzf};

  // Stage 3: round the integer to 53 bits, nearest even
  assign sig_a = m2_q[63:11];
  assign ga    = m2_q[10];
  assign sta   = |m2_q[9:0];
  assign sa    = {1'b0, sig_a} + 54'(ga & (sta | sig_a[0]));

  // Stage 7: one-bit normalize, exponent, subnormal shift amount
  assign top  = prod_q[105];
  assign norm = top ? prod_q : (prod_q << 1);
  assign bexp = biased_q + 13'(top);
  assign amt  = 13'sd1 - bexp;

  // Stage 8: denormalize with sticky collection
  assign ysh  = x_q >> sh_q;
  assign lost = |(x_q & ((55'd1 << sh_q) - 55'd1));

  // Stage 9: final rounding and special values
  assign m8   = meta_q[NumStg-2];
  assign body = {field8_q, sig8_q[51:0]} + 63'(g8_q & (st8_q | sig8_q[0]));
  always_comb begin
    if (m8.zero) begin
      value = '0;
    end else if ((m8.pcls == PCLS_HUGE) || ovf8_q) begin
      value = {m8.neg, EXP_ALL_ONES, 52'd0};
    end else if (m8.pcls == PCLS_TINY) begin
      value = {m8.neg, 63'd0};
    end else begin
      value = {m8.neg, body};
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1
      m1_q   <= m0 << {lzb, 3'b000};
      lzb_q  <= lzb;
      pidx_q <= job_i.pidx;
      // stage 2
      m2_q   <= m1_q << lzf;
      ea2_q  <= 6'd63 - lzt;
      rom_q  <= pow_rom[pidx_q];
      // stage 3
      if (sa[53]) begin
        siga_q <= sa[53:1];
        ea3_q  <= {1'b0, ea2_q} + 7'd1;
      end else begin
        siga_q <= sa[52:0];
        ea3_q  <= {1'b0, ea2_q};
      end
      sigb_q <= {1'b1, rom_q[51:0]};
      eb_q   <= rom_q[63:52];
      // stage 4
      pp_ll_q <= siga_q[31:0] * sigb_q[31:0];
      pp_lh_q <= 53'(siga_q[31:0]) * 53'(sigb_q[52:32]);
      pp_hl_q <= 53'(siga_q[52:32]) * 53'(sigb_q[31:0]);
      pp_hh_q <= 42'(siga_q[52:32]) * 42'(sigb_q[52:32]);
      esum4_q <= signed'({eb_q[11], eb_q}) + signed'({6'd0, ea3_q});
      // stage 5
      pp_ll5_q <= pp_ll_q;
      mid_q    <= 54'(pp_lh_q) + 54'(pp_hl_q);
      pp_hh5_q <= pp_hh_q;
      esum5_q  <= esum4_q;
      // stage 6
      prod_q   <= {pp_hh5_q, 64'd0} + 106'({mid_q, 32'd0}) + 106'(pp_ll5_q);
      biased_q <= esum5_q + 13'sd1023;
      // stage 7
      x_q    <= {norm[105:52], |norm[51:0]};
      ovf7_q <= bexp >= 13'sd2047;
      if (bexp <= 13'sd0) begin
        field7_q <= '0;
        sh_q     <= (amt > 13'sd55) ? 6'd55 : amt[5:0];
      end else begin
        field7_q <= bexp[10:0];
        sh_q     <= '0;
      end
      // stage 8
      sig8_q   <= ysh[54:2];
      g8_q     <= ysh[1];
      st8_q    <= ysh[0] | lost;
      field8_q <= field7_q;
      ovf8_q   <= ovf7_q;
      // stage 9
      out_q <= value;
    end
  end

endmodule

// ===== test/tb_decimal_text_to_double_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_double_unit: self-checking bench of the text to double
// Streams character text into the unit, computes each expected double and
// end character alongside, and compares every value transfer in order, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_double_unit;
  import dtd_pkg::*;

  localparam int  ExpMax      = (1 << 19) - 1;
  localparam int  ItemTarget  = 850;
  localparam int  CycleLimit  = 400000;
  localparam int  PauseAt     = 450;
  localparam int  HoldStart   = 1500;
  localparam int  HoldLength  = 300;

  typedef enum logic [2:0] {
    TP_START, TP_INT, TP_FRAC, TP_ESIGN, TP_EDIG
  } text_phase_e;

  typedef struct {
    logic [63:0] bits;
    logic [7:0]  endc;
  } number_t;

  logic clk_i;
  logic rst_ni;

  dtd_char_if  char_bus ();
  dtd_value_if value_bus ();

  decimal_text_to_double_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_bus),
    .value_o(value_bus)
  );

  // Parser copy kept by the bench
  text_phase_e  tp;
  logic         neg_r;
  logic [62:0]  mant_r;
  longint       dexp_r;
  longint       eexp_r;
  logic         eneg_r;

  logic [7:0]   text_q[$];
  number_t      numbers_q[$];
  int           errors;
  int           accepted;
  int           results;
  int           cycles;
  int           gap_left;
  int           rdy_gap;
  bit           paused_done;

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  function automatic real pow10_of(int k);
    string s;
    s = $sformatf("1e%0d", k);
    return s.atoreal();
  endfunction

  function automatic logic [63:0] number_bits();
    longint p;
    real    v;
    logic [63:0] b;
    p = dexp_r + (eneg_r ? -eexp_r : eexp_r);
    if (mant_r == '0) return 64'd0;
    if (p > POW_MAX) v = 1e308 * 10.0;
    else if (p < POW_MIN) v = 0.0;
    else v = real'(mant_r) * pow10_of(int'(p));
    b = $realtobits(v);
    if (neg_r) b[63] = ~b[63];
    return b;
  endfunction

  task automatic clear_number();
    tp     = TP_START;
    neg_r  = 1'b0;
    mant_r = '0;
    dexp_r = 0;
    eexp_r = 0;
    eneg_r = 1'b0;
  endtask

  task automatic bump_dexp(longint d);
    dexp_r = dexp_r + d;
    if (dexp_r > ExpMax) dexp_r = ExpMax;
    if (dexp_r < -ExpMax - 1) dexp_r = -ExpMax - 1;
  endtask

  // Advance the parser copy by one character; queue a number when it ends
  task automatic parse_char(logic [7:0] c);
    bit      digit;
    bit      emark;
    number_t n;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    emark = (c == CH_E_LO) || (c == CH_E_UP);
    case (tp)
      TP_FRAC: begin
        if (digit) begin
          if (mant_r <= ACCEPT_LIMIT) begin
            mant_r = mant_r * 10 + 63'(c - CH_ZERO);
            bump_dexp(-1);
          end
          return;
        end
        if (emark) begin
          tp = TP_ESIGN;
          return;
        end
      end
      TP_ESIGN, TP_EDIG: begin
        if (digit) begin
          eexp_r = eexp_r * 10 + longint'(c - CH_ZERO);
          if (eexp_r > ExpMax) eexp_r = ExpMax;
          tp = TP_EDIG;
          return;
        end
        if (tp == TP_ESIGN && c == CH_MINUS) begin
          eneg_r = 1'b1;
          tp     = TP_EDIG;
          return;
        end
      end
      default: begin
        if (digit) begin
          if (mant_r <= ACCEPT_LIMIT) mant_r = mant_r * 10 + 63'(c - CH_ZERO);
          else bump_dexp(1);
          tp = TP_INT;
          return;
        end
        if (tp != TP_INT && c == CH_MINUS) begin
          neg_r = 1'b1;
          tp    = TP_INT;
          return;
        end
        if (c == CH_DOT) begin
          tp = TP_FRAC;
          return;
        end
        if (emark) begin
          tp = TP_ESIGN;
          return;
        end
      end
    endcase
    n.bits = number_bits();
    n.endc = c;
    numbers_q.push_back(n);
    clear_number();
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Terminator: a random byte outside the grammar
  function automatic logic [7:0] pick_end();
    logic [7:0] c;
    c = 8'($urandom);
    while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_DOT ||
           c == CH_E_LO || c == CH_E_UP)
      c = 8'($urandom);
    return c;
  endfunction

  task automatic push_random_number();
    int r;
    if ($urandom_range(3) == 0) text_q.push_back(CH_MINUS);
    r = $urandom_range(19);
    push_digits(r == 0 ? $urandom_range(30, 19) : $urandom_range(6));
    if ($urandom_range(1)) begin
      text_q.push_back(CH_DOT);
      push_digits($urandom_range(19) == 0 ? $urandom_range(30, 15) : $urandom_range(5));
    end
    if ($urandom_range(2) == 0) begin
      text_q.push_back($urandom_range(1) ? CH_E_LO : CH_E_UP);
      if ($urandom_range(1)) text_q.push_back(CH_MINUS);
      push_digits($urandom_range(9) == 0 ? $urandom_range(8, 4) : $urandom_range(3));
    end
    text_q.push_back(pick_end());
  endtask

  // Fill the text queue, then wait for the end of the run
  initial begin
    errors      = 0;
    accepted    = 0;
    results     = 0;
    paused_done = 1'b0;
    clear_number();
    rst_ni = 1'b0;
    push_text("0 ");
    text_q.push_back(8'h00);
    text_q.push_back(CH_MINUS);
    text_q.push_back(8'hff);
    push_text("-12.5e3,9E-2;.e-x1e400x1e-400x-1e-400x1e9999999x");
    push_text("-0.0e5 -1.x12e");
    text_q.push_back(8'h80);
    push_text("922337203685477580799999.99999e-3 1234567890123456789012345.5 ");
    while (text_q.size() < ItemTarget) begin
      if ($urandom_range(9) == 0) text_q.push_back(8'($urandom));
      else push_random_number();
    end
    text_q.push_back(8'h20);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (text_q.size() == 0 && !char_bus.valid);
    wait (numbers_q.size() == 0);
    repeat (30) @(posedge clk_i);
    $display("Run: %0d characters streamed, %0d numbers checked, %0d mismatches.",
             accepted, results, errors);
    $display("Covered signs, fractions, both exponent marks, mantissa cap, range ends.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Cycle count and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial cycles = 0;

  // Character driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_bus.valid     <= 1'b0;
      char_bus.char_code <= 8'h00;
      gap_left           <= 0;
    end else begin
      if (char_bus.valid && char_bus.ready) begin
        parse_char(char_bus.char_code);
        accepted++;
      end
      if (!(char_bus.valid && !char_bus.ready)) begin
        if (accepted == PauseAt && !paused_done) begin
          // hold off until every pending number has come out
          char_bus.valid <= 1'b0;
          if (numbers_q.size() == 0) paused_done = 1'b1;
        end else if (gap_left > 0) begin
          char_bus.valid <= 1'b0;
          gap_left       <= gap_left - 1;
        end else if (text_q.size() > 0) begin
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= text_q.pop_front();
          gap_left           <= (accepted > 100 && accepted < 250) ? 0 : pick_gap();
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Value monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_bus.ready <= 1'b0;
      rdy_gap         <= 0;
    end else begin
      if (value_bus.valid && value_bus.ready) begin
        results++;
        if (numbers_q.size() == 0) begin
          report_mismatch("unexpected transfer", value_bus.value_bits, 64'd0);
        end else begin
          number_t n;
          n = numbers_q.pop_front();
          if (value_bus.value_bits !== n.bits)
            report_mismatch("value_bits", value_bus.value_bits, n.bits);
          if (value_bus.end_char !== n.endc)
            report_mismatch("end_char", 64'(value_bus.end_char), 64'(n.endc));
        end
      end
      if (cycles >= HoldStart && cycles < HoldStart + HoldLength) begin
        value_bus.ready <= 1'b0;
      end else if (rdy_gap > 0) begin
        value_bus.ready <= 1'b0;
        rdy_gap         <= rdy_gap - 1;
      end else begin
        value_bus.ready <= 1'b1;
        rdy_gap         <= (cycles > 2500 && cycles < 3500) ? 0 : pick_gap();
      end
    end
  end

endmodule
